// ===== hdl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time iteration block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int C_W       = 32;
    localparam int ZW        = FRAC_BITS + 6;
    localparam int PW        = 2 * ZW;
    localparam int CFG_W     = 13;
    localparam int COUNT_W   = 12;

    localparam logic [CFG_W-1:0] MAX_ITER_RESET = 13'd2000;

    // 4.0 at 2*FRAC_BITS fraction bits, one bit wider than a product
    localparam logic [PW:0] ESC_BOUND =
        {{(PW + 1 - 3 - 2 * FRAC_BITS){1'b0}}, 3'b100, {(2 * FRAC_BITS){1'b0}}};

    typedef struct packed {
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
    } point_t;

    typedef struct packed {
        logic               escaped;
        logic [COUNT_W-1:0] escape_count;
    } result_t;

    typedef enum logic [1:0] {
        MUL_SQA,
        MUL_SQB,
        MUL_CROSS
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_CROSS,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t sel;
        logic     upd;
    } ctrl_t;

endpackage

// ===== hdl/mbe_datapath.sv =====
// ----------------------------------------------------------------------------
// mbe_datapath
// z registers, one shared signed multiplier, product registers, escape test.
// ----------------------------------------------------------------------------
module mbe_datapath
    import mbe_pkg::*;
(
    input  logic   clk,
    input  ctrl_t  ctrl,
    input  point_t point,
    output logic   esc
);

    logic signed [ZW-1:0] cr_reg;
    logic signed [ZW-1:0] ci_reg;
    logic signed [ZW-1:0] za_reg;
    logic signed [ZW-1:0] zb_reg;
    logic signed [PW-1:0] sqa_reg;
    logic signed [PW-1:0] sqb_reg;
    logic signed [PW-1:0] cross_reg;

    logic signed [ZW-1:0] mul_a;
    logic signed [ZW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW:0]   diff;
    logic signed [PW:0]   re_full;
    logic signed [PW:0]   im_full;
    logic [PW:0]          mag_sum;
    logic signed [ZW-1:0] za_next;
    logic signed [ZW-1:0] zb_next;

    always_comb
    begin
        case (ctrl.sel)
            MUL_SQA:
            begin
                mul_a = za_reg;
                mul_b = za_reg;
            end
            MUL_SQB:
            begin
                mul_a = zb_reg;
                mul_b = zb_reg;
            end
            MUL_CROSS:
            begin
                mul_a = za_reg;
                mul_b = zb_reg;
            end
            default:
            begin
                mul_a = za_reg;
                mul_b = zb_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // arithmetic shift gives floor
    assign diff    = {sqa_reg[PW-1], sqa_reg} - {sqb_reg[PW-1], sqb_reg};
    assign re_full = diff >>> FRAC_BITS;
    assign im_full = $signed({cross_reg, 1'b0}) >>> FRAC_BITS;
    assign za_next = re_full[ZW-1:0] + cr_reg;
    assign zb_next = im_full[ZW-1:0] + ci_reg;

    // squares are non-negative
    assign mag_sum = {1'b0, sqa_reg} + {1'b0, sqb_reg};
    assign esc     = mag_sum > ESC_BOUND;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cr_reg <= ZW'(point.c_real);
            ci_reg <= ZW'(point.c_imag);
            za_reg <= '0;
            zb_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            za_reg <= za_next;
            zb_reg <= zb_next;
        end
        if (ctrl.mul_en)
        begin
            case (ctrl.sel)
                MUL_SQA:   sqa_reg   <= prod;
                MUL_SQB:   sqb_reg   <= prod;
                MUL_CROSS: cross_reg <= prod;
                default:   cross_reg <= prod;
            endcase
        end
    end

endmodule

// ===== hdl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Pass sequencer: iteration count, limit check, result register and strobe.
// ----------------------------------------------------------------------------
module mbe_ctrl
    import mbe_pkg::*;
#(
    parameter int MAX_ITER_LIMIT = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CFG_W-1:0] max_iterations,
    input  logic             esc,
    output ctrl_t            ctrl,
    output logic             busy,
    output logic             done,
    output result_t          result
);

    localparam int CW = $clog2(MAX_ITER_LIMIT + 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   iter_reg;
    logic [CW-1:0]   iter_next;
    logic [CW-1:0]   limit_reg;
    logic [CW-1:0]   limit_next;
    logic            done_reg;
    logic            done_next;
    result_t         result_reg;
    result_t         result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg   <= iter_next;
        limit_reg  <= limit_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        limit_next  = limit_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ctrl        = '{load: 1'b0, mul_en: 1'b0, sel: MUL_SQA, upd: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    iter_next = '0;
                    if (32'(max_iterations) > 32'(MAX_ITER_LIMIT))
                        limit_next = CW'(MAX_ITER_LIMIT);
                    else
                        limit_next = CW'(max_iterations);
                    state_next = ST_SQA;
                end
            end
            ST_SQA:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.sel    = MUL_SQA;
                state_next  = ST_SQB;
            end
            ST_SQB:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.sel    = MUL_SQB;
                state_next  = ST_CROSS;
            end
            ST_CROSS:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.sel    = MUL_CROSS;
                if (iter_reg == limit_reg)
                begin
                    result_next = '{escaped: 1'b0, escape_count: '0};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (esc)
                begin
                    result_next = '{escaped: 1'b1, escape_count: COUNT_W'(iter_reg)};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                ctrl.upd   = 1'b1;
                iter_next  = iter_reg + 1'b1;
                state_next = ST_SQA;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of z = z*z + c for one point, exact fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   An item (c_real, c_imag, Q4.28) is taken on point when start is high and
//   busy is low. busy stays high while the point iterates.
//   One result per item appears on result for a single cycle with done high;
//   the receiver cannot stall it, so it must take it then.
//   Each pass uses the one shared 34x34 multiplier three times (za^2, zb^2,
//   za*zb) and then updates z. A point that escapes at pass k gives done
//   with escape_count k; a point in the set gives done with escaped low
//   after n passes, n being max_iterations capped at MAX_ITER_LIMIT.
//   max_iterations is written on cfg_data when cfg_valid is high (cfg_ready
//   is always high); write it only while idle.
//   Reset sets max_iterations to 2000 and returns the sequencer to idle;
//   an item in flight is dropped.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int MAX_ITER_LIMIT = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  point_t           point,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] max_iterations_reg;
    logic [CFG_W-1:0] max_iterations_next;
    ctrl_t            ctrl;
    logic             esc;
    logic             busy_int;

    assign cfg_ready = 1'b1;
    assign max_iterations_next = (cfg_valid && cfg_ready) ? cfg_data : max_iterations_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_iterations_reg <= MAX_ITER_RESET;
        else
            max_iterations_reg <= max_iterations_next;
    end

    mbe_ctrl #(
        .MAX_ITER_LIMIT (MAX_ITER_LIMIT)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .max_iterations (max_iterations_reg),
        .esc            (esc),
        .ctrl           (ctrl),
        .busy           (busy_int),
        .done           (done),
        .result         (result)
    );

    mbe_datapath u_datapath (
        .clk   (clk),
        .ctrl  (ctrl),
        .point (point),
        .esc   (esc)
    );

    assign busy = busy_int;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the escape-time iteration block.
// Points are driven on the start/busy command port. Each accepted item is run
// through an exact fixed-point predictor of z = z*z + c. The single-cycle
// results are compared in order against the queue of predicted outcomes.
// The pass limit is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import mbe_pkg::*;

    localparam int ITER_CAP   = 4096;
    localparam int STALL_MAX  = 60000;
    localparam int Q_ONE      = 1 << FRAC_BITS;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    point_t           point;
    logic             done;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int unsigned      items_sent = 0;
    int unsigned      stall_cycles = 0;

    mandelbrot_escape_time dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    class escape_scoreboard;
        int unsigned iter_limit = 2000;
        int unsigned errors     = 0;
        result_t     outcomes[$];

        function result_t predict_escape(point_t p);
            longint      cr;
            longint      ci;
            longint      za;
            longint      zb;
            longint      re;
            longint      im;
            longint      ma;
            longint      mb;
            longint      two;
            longint      four_sq;
            int unsigned n;
            int unsigned i;
            result_t     r;
            cr      = p.c_real;
            ci      = p.c_imag;
            za      = 0;
            zb      = 0;
            two     = longint'(2) << FRAC_BITS;
            four_sq = longint'(4) << (2 * FRAC_BITS);
            n       = (iter_limit > ITER_CAP) ? ITER_CAP : iter_limit;
            r       = '0;
            for (i = 0; i < n; i++)
            begin
                ma = (za < 0) ? -za : za;
                mb = (zb < 0) ? -zb : zb;
                if (ma > two || mb > two || ma * ma + mb * mb > four_sq)
                begin
                    r.escaped      = 1'b1;
                    r.escape_count = COUNT_W'(i);
                    return r;
                end
                re = (za * za - zb * zb) >>> FRAC_BITS;
                im = (2 * za * zb) >>> FRAC_BITS;
                za = re + cr;
                zb = im + ci;
            end
            return r;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            iter_limit = 32'(v);
        endfunction

        function void note_point(point_t p);
            outcomes.push_back(predict_escape(p));
        endfunction

        function void check_result(result_t r);
            result_t exp_r;
            if (outcomes.size() == 0)
            begin
                $display("%0t: unexpected result escaped=%0d count=%0d",
                         $time, r.escaped, r.escape_count);
                errors++;
                return;
            end
            exp_r = outcomes.pop_front();
            if (r.escaped !== exp_r.escaped)
            begin
                $display("%0t: escaped expected %0d got %0d",
                         $time, exp_r.escaped, r.escaped);
                errors++;
            end
            if (r.escape_count !== exp_r.escape_count)
            begin
                $display("%0t: escape_count expected %0d got %0d",
                         $time, exp_r.escape_count, r.escape_count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return outcomes.size();
        endfunction
    endclass

    escape_scoreboard sb;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done && sb != null)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic point_t mk_point(int re, int im);
        point_t p;
        p.c_real = re;
        p.c_imag = im;
        return p;
    endfunction

    function automatic point_t random_point();
        int unsigned kind;
        int          base_re[4];
        int          base_im[4];
        int unsigned sel;
        point_t      p;
        base_re = '{-(3 * Q_ONE / 4), Q_ONE / 4, -(5 * Q_ONE / 4), -(Q_ONE / 8)};
        base_im = '{0, 0, 0, 3 * Q_ONE / 4};
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            p.c_real = $urandom;
            p.c_imag = $urandom;
        end
        else if (kind < 75)
        begin
            p.c_real = int'($urandom_range(0, 3 * Q_ONE)) - (9 * (Q_ONE / 4));
            p.c_imag = int'($urandom_range(0, 3 * Q_ONE)) - (3 * Q_ONE / 2);
        end
        else
        begin
            sel      = $urandom_range(0, 3);
            p.c_real = base_re[sel] + int'($urandom_range(0, 1 << 21)) - (1 << 20);
            p.c_imag = base_im[sel] + int'($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        return p;
    endfunction

    // called right after a rising edge; start is left high on return
    task automatic send_point(point_t p);
        while (!(items_sent >= 130 && items_sent < 200) && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (busy);
        sb.note_point(p);
        items_sent++;
    endtask

    task automatic write_iter_limit(logic [CFG_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned lim;
        int unsigned cnt;
        int unsigned ph;
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        point     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 2000
        send_point(mk_point(0, 0));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_point(mk_point(32'h8000_0000, 32'h8000_0000));
        send_point(mk_point(2 * Q_ONE, 0));
        send_point(mk_point(-2 * Q_ONE, 0));
        send_point(mk_point(0, 2 * Q_ONE));
        send_point(mk_point(Q_ONE / 4, 0));
        send_point(mk_point(Q_ONE / 4 + (1 << 14), 0));
        send_point(mk_point(Q_ONE, Q_ONE));
        send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000));
        send_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF));

        // no passes at all
        write_iter_limit('0);
        send_point(mk_point(0, 0));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF));

        // single pass: nothing can escape at index zero
        write_iter_limit(CFG_W'(1));
        send_point(mk_point(32'h8000_0000, 32'h8000_0000));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF));

        // all ones saturates to the cap
        write_iter_limit('1);
        send_point(mk_point(2 * Q_ONE, 2 * Q_ONE));
        send_point(mk_point(-Q_ONE, 0));
        send_point(mk_point(Q_ONE / 4 + (1 << 14), 0));

        write_iter_limit(CFG_W'(ITER_CAP));
        send_point(mk_point(0, 0));
        send_point(mk_point(-(3 * Q_ONE / 4), 1 << 18));

        write_iter_limit(CFG_W'(ITER_CAP + 1));
        send_point(mk_point(-(3 * Q_ONE / 4), 1 << 18));

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: lim = $urandom_range(2, 16);
                1: lim = $urandom_range(17, 64);
                2: lim = $urandom_range(65, 255);
                3: lim = $urandom_range(1, 64);
                4: lim = $urandom_range(1, 32);
                default: lim = $urandom_range(256, 8191);
            endcase
            write_iter_limit(lim[CFG_W-1:0]);
            cnt = (lim > 300) ? 4 : 60;
            repeat (cnt) send_point(random_point());
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
